@@ sv/tld_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tld_pkg
// Shared constants and codes for the TIFF LZW decoder.
// ----------------------------------------------------------------------------
package tld_pkg;

  localparam int DICT_SIZE_DEF     = 4096;
  localparam int MAX_CODE_BITS_DEF = 12;
  localparam int LENGTH_BITS_DEF   = 24;

  localparam int MIN_CODE_BITS = 9;
  localparam int ROOT_COUNT    = 256;
  localparam int CODE_CLEAR    = 256;
  localparam int CODE_END      = 257;
  localparam int CODE_FIRST    = 258;

  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_PULL    = 2'd1,
    OP_RESTART = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_RUN  = 3'd0,
    ST_END  = 3'd1,
    ST_LEN  = 3'd2,
    ST_INEX = 3'd3,
    ST_ERR  = 3'd4
  } run_status_t;

endpackage

@@ sv/tld_dict.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tld_dict
// Prefix and suffix tables of the LZW dictionary, one write and one
// registered read per cycle.
// ----------------------------------------------------------------------------
module tld_dict #(
  parameter int IDX_W  = 12,
  parameter int CODE_W = 12
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_addr,
  input  logic [CODE_W-1:0] wr_prefix,
  input  logic [7:0]        wr_suffix,
  input  logic              rd_en,
  input  logic [IDX_W-1:0]  rd_addr,
  output logic [CODE_W-1:0] rd_prefix,
  output logic [7:0]        rd_suffix
);

  logic [CODE_W-1:0] prefix_mem [2**IDX_W];
  logic [7:0]        suffix_mem [2**IDX_W];

  // Write new entry, register the read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      prefix_mem[wr_addr] <= wr_prefix;
      suffix_mem[wr_addr] <= wr_suffix;
    end
    if (rd_en) begin
      rd_prefix <= prefix_mem[rd_addr];
      rd_suffix <= suffix_mem[rd_addr];
    end
  end

endmodule

@@ sv/tld_stack.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tld_stack
// String stack: decoded bytes are pushed last byte first and popped in order.
// ----------------------------------------------------------------------------
module tld_stack #(
  parameter int IDX_W = 12
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [7:0]       wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [7:0]       rd_data
);

  logic [7:0] stack_mem [2**IDX_W];

  // Push byte, register the pop read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= stack_mem[rd_addr];
    end
  end

endmodule

@@ sv/tiff_lzw_decoder_unit.sv @@
`timescale 1ns / 1ps
// Sequence: an accepted beat passes through S_SETTLE and then S_DONE, where its result
//   is registered. A pull first reads the stack in S_PULL, and a clear, end or bad code is
//   consumed in S_SETTLE, which then runs again. A code's string is walked in S_CHAIN and
//   S_FETCH: one check, then a read and a push per byte.
// Throughput: one beat at a time; ready returns as the result is registered,
//   later while a previous result still waits.
// Reset (rst_n, synchronous): status running, width 9, next code 258, empty
//   stack and bit buffer, lengths zero. Table contents are not cleared.
// ----------------------------------------------------------------------------
// tiff_lzw_decoder_unit
// TIFF LZW decoder: MSB-first codes of 9 to MAX_CODE_BITS bits with early
// width change, prefix chain walked one byte per step under a small sequencer.
// ----------------------------------------------------------------------------
module tiff_lzw_decoder_unit
  import tld_pkg::*;
#(
  parameter int DICT_SIZE     = DICT_SIZE_DEF,
  parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF,
  parameter int LENGTH_BITS   = LENGTH_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             in_opcode,
  input  logic [7:0]             in_data_byte,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_out_valid,
  output logic [7:0]             out_out_byte,
  output logic                   out_push_accepted,
  output logic [2:0]             out_status,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [LENGTH_BITS-1:0] cfg_wdata
);

  localparam int CODE_W = MAX_CODE_BITS;
  localparam int IDX_W  = $clog2(DICT_SIZE);
  localparam int CNT_W  = IDX_W + 1;
  localparam int NEXT_W = IDX_W + 1;
  localparam int BUF_W  = MAX_CODE_BITS + 8;
  localparam int HELD_W = $clog2(BUF_W + 1);
  localparam int WID_W  = $clog2(MAX_CODE_BITS + 1);
  localparam int CMP_W  = ((CODE_W > NEXT_W) ? CODE_W : NEXT_W) + 1;
  localparam int LEN_W  = LENGTH_BITS;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_PULL   = 6'b000010,
    S_SETTLE = 6'b000100,
    S_CHAIN  = 6'b001000,
    S_FETCH  = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [LEN_W-1:0]  out_len_r, in_len_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [BUF_W-1:0]  buf_r, buf_nxt;
  logic [HELD_W-1:0] held_r, held_nxt;
  logic [WID_W-1:0]  wid_r, wid_nxt;
  logic [NEXT_W-1:0] nc_r, nc_nxt;
  logic [CODE_W-1:0] prev_r, prev_nxt;
  logic              pv_r, pv_nxt;
  logic [7:0]        pfirst_r, pfirst_nxt;
  logic [LEN_W-1:0]  bout_r, bout_nxt;
  logic [LEN_W-1:0]  bin_r, bin_nxt;
  logic [2:0]        status_r, status_nxt;
  logic [CODE_W-1:0] cur_r, cur_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;
  logic              rvalid_r, rvalid_nxt;
  logic [7:0]        rbyte_r, rbyte_nxt;
  logic              racc_r, racc_nxt;
  logic              ov_r, ov_nxt;
  logic              oval_r, oval_nxt;
  logic [7:0]        obyte_r, obyte_nxt;
  logic              oacc_r, oacc_nxt;
  logic [2:0]        ostat_r, ostat_nxt;

  logic              stk_we, stk_re;
  logic [IDX_W-1:0]  stk_waddr, stk_raddr;
  logic [7:0]        stk_wdata, stk_rdata;
  logic              dict_we, dict_re;
  logic [IDX_W-1:0]  dict_waddr, dict_raddr;
  logic [CODE_W-1:0] dict_wprefix, dict_rprefix;
  logic [7:0]        dict_wsuffix, dict_rsuffix;

  logic [HELD_W-1:0] shift_amt;
  logic [BUF_W-1:0]  shifted, code_mask, rem_mask;
  logic [CODE_W-1:0] code_now;
  logic [NEXT_W-1:0] nc_inc;
  logic              grow;
  logic              in_fire;

  tld_dict #(.IDX_W(IDX_W), .CODE_W(CODE_W)) u_dict (
    .clk       (clk),
    .wr_en     (dict_we),
    .wr_addr   (dict_waddr),
    .wr_prefix (dict_wprefix),
    .wr_suffix (dict_wsuffix),
    .rd_en     (dict_re),
    .rd_addr   (dict_raddr),
    .rd_prefix (dict_rprefix),
    .rd_suffix (dict_rsuffix)
  );

  tld_stack #(.IDX_W(IDX_W)) u_stack (
    .clk     (clk),
    .wr_en   (stk_we),
    .wr_addr (stk_waddr),
    .wr_data (stk_wdata),
    .rd_en   (stk_re),
    .rd_addr (stk_raddr),
    .rd_data (stk_rdata)
  );

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  // Extract the head code of the bit buffer
  assign shift_amt = held_r - HELD_W'(wid_r);
  assign shifted   = buf_r >> shift_amt;
  assign code_mask = (BUF_W'(1) << wid_r) - BUF_W'(1);
  assign rem_mask  = (BUF_W'(1) << shift_amt) - BUF_W'(1);
  assign code_now  = CODE_W'(shifted & code_mask);

  // Early width change after a new entry
  assign nc_inc = nc_r + NEXT_W'(1);
  assign grow   = ((CMP_W'(nc_inc) + CMP_W'(1)) == (CMP_W'(1) << wid_r)) &&
                  (wid_r < WID_W'(MAX_CODE_BITS));

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    buf_nxt    = buf_r;
    held_nxt   = held_r;
    wid_nxt    = wid_r;
    nc_nxt     = nc_r;
    prev_nxt   = prev_r;
    pv_nxt     = pv_r;
    pfirst_nxt = pfirst_r;
    bout_nxt   = bout_r;
    bin_nxt    = bin_r;
    status_nxt = status_r;
    cur_nxt    = cur_r;
    code_nxt   = code_r;
    rvalid_nxt = rvalid_r;
    rbyte_nxt  = rbyte_r;
    racc_nxt   = racc_r;
    ov_nxt     = ov_r && !out_ready;
    oval_nxt   = oval_r;
    obyte_nxt  = obyte_r;
    oacc_nxt   = oacc_r;
    ostat_nxt  = ostat_r;
    stk_we       = 1'b0;
    stk_waddr    = cnt_r[IDX_W-1:0];
    stk_wdata    = cur_r[7:0];
    stk_re       = 1'b0;
    stk_raddr    = IDX_W'(cnt_r - CNT_W'(1));
    dict_we      = 1'b0;
    dict_waddr   = IDX_W'(nc_r);
    dict_wprefix = prev_r;
    dict_wsuffix = cur_r[7:0];
    dict_re      = 1'b0;
    dict_raddr   = IDX_W'(cur_r);

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          rvalid_nxt = 1'b0;
          rbyte_nxt  = 8'd0;
          racc_nxt   = 1'b0;
          state_nxt  = S_SETTLE;
          case (op_t'(in_opcode))
            OP_PUSH: begin
              if (status_r == ST_RUN && bin_r < in_len_r &&
                  held_r <= HELD_W'(MAX_CODE_BITS)) begin
                buf_nxt  = {buf_r[BUF_W-9:0], in_data_byte};
                held_nxt = held_r + HELD_W'(8);
                bin_nxt  = bin_r + LEN_W'(1);
                racc_nxt = 1'b1;
              end
            end
            OP_PULL: begin
              if (status_r == ST_RUN && bout_r < out_len_r &&
                  cnt_r != '0) begin
                cnt_nxt    = cnt_r - CNT_W'(1);
                stk_re     = 1'b1;
                rvalid_nxt = 1'b1;
                bout_nxt   = bout_r + LEN_W'(1);
                state_nxt  = S_PULL;
              end
            end
            OP_RESTART: begin
              cnt_nxt    = '0;
              buf_nxt    = '0;
              held_nxt   = '0;
              wid_nxt    = WID_W'(MIN_CODE_BITS);
              nc_nxt     = NEXT_W'(CODE_FIRST);
              pv_nxt     = 1'b0;
              bout_nxt   = '0;
              bin_nxt    = '0;
              status_nxt = ST_RUN;
            end
            default: begin
            end
          endcase
        end
      end

      S_PULL: begin
        rbyte_nxt = stk_rdata;
        state_nxt = S_SETTLE;
      end

      S_SETTLE: begin
        if (status_r != ST_RUN) begin
          state_nxt = S_DONE;
        end else if (bout_r >= out_len_r) begin
          status_nxt = ST_LEN;
          cnt_nxt    = '0;
          state_nxt  = S_DONE;
        end else if (cnt_r != '0) begin
          state_nxt = S_DONE;
        end else if (held_r < HELD_W'(wid_r)) begin
          if (bin_r >= in_len_r) status_nxt = ST_INEX;
          state_nxt = S_DONE;
        end else begin
          // Consume one code
          held_nxt = shift_amt;
          buf_nxt  = buf_r & rem_mask;
          code_nxt = code_now;
          if (code_now == CODE_W'(CODE_CLEAR)) begin
            wid_nxt = WID_W'(MIN_CODE_BITS);
            nc_nxt  = NEXT_W'(CODE_FIRST);
            pv_nxt  = 1'b0;
          end else if (code_now == CODE_W'(CODE_END)) begin
            status_nxt = ST_END;
          end else if (CMP_W'(code_now) > CMP_W'(nc_r) ||
                       (CMP_W'(code_now) == CMP_W'(nc_r) && !pv_r)) begin
            status_nxt = ST_ERR;
            cnt_nxt    = '0;
          end else if (CMP_W'(code_now) == CMP_W'(nc_r)) begin
            // Repeated string: previous string plus its first byte
            stk_we    = 1'b1;
            stk_waddr = '0;
            stk_wdata = pfirst_r;
            cnt_nxt   = CNT_W'(1);
            cur_nxt   = prev_r;
            state_nxt = S_CHAIN;
          end else begin
            cnt_nxt   = '0;
            cur_nxt   = code_now;
            state_nxt = S_CHAIN;
          end
        end
      end

      S_CHAIN: begin
        if (cur_r >= CODE_W'(ROOT_COUNT) && cnt_r < CNT_W'(DICT_SIZE - 1)) begin
          dict_re   = 1'b1;
          state_nxt = S_FETCH;
        end else begin
          // Push root byte; extend the dictionary if a previous code exists and it has room
          stk_we     = 1'b1;
          cnt_nxt    = cnt_r + CNT_W'(1);
          if (pv_r && nc_r < NEXT_W'(DICT_SIZE)) begin
            dict_we = 1'b1;
            nc_nxt  = nc_inc;
            if (grow) wid_nxt = wid_r + WID_W'(1);
          end
          prev_nxt   = code_r;
          pv_nxt     = 1'b1;
          pfirst_nxt = cur_r[7:0];
          state_nxt  = S_SETTLE;
        end
      end

      S_FETCH: begin
        stk_we    = 1'b1;
        stk_wdata = dict_rsuffix;
        cnt_nxt   = cnt_r + CNT_W'(1);
        cur_nxt   = dict_rprefix;
        state_nxt = S_CHAIN;
      end

      S_DONE: begin
        if (!ov_r || out_ready) begin
          ov_nxt    = 1'b1;
          oval_nxt  = rvalid_r;
          obyte_nxt = rbyte_r;
          oacc_nxt  = racc_r;
          ostat_nxt = status_r;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_len_r <= '0;
      in_len_r  <= '0;
      cnt_r     <= '0;
      buf_r     <= '0;
      held_r    <= '0;
      wid_r     <= WID_W'(MIN_CODE_BITS);
      nc_r      <= NEXT_W'(CODE_FIRST);
      pv_r      <= 1'b0;
      bout_r    <= '0;
      bin_r     <= '0;
      status_r  <= ST_RUN;
      ov_r      <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      buf_r    <= buf_nxt;
      held_r   <= held_nxt;
      wid_r    <= wid_nxt;
      nc_r     <= nc_nxt;
      pv_r     <= pv_nxt;
      bout_r   <= bout_nxt;
      bin_r    <= bin_nxt;
      status_r <= status_nxt;
      ov_r     <= ov_nxt;
      if (cfg_we) begin
        if (cfg_index) in_len_r <= cfg_wdata;
        else           out_len_r <= cfg_wdata;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    prev_r   <= prev_nxt;
    pfirst_r <= pfirst_nxt;
    cur_r    <= cur_nxt;
    code_r   <= code_nxt;
    rvalid_r <= rvalid_nxt;
    rbyte_r  <= rbyte_nxt;
    racc_r   <= racc_nxt;
    oval_r   <= oval_nxt;
    obyte_r  <= obyte_nxt;
    oacc_r   <= oacc_nxt;
    ostat_r  <= ostat_nxt;
  end

  assign out_valid         = ov_r;
  assign out_out_valid     = oval_r;
  assign out_out_byte      = obyte_r;
  assign out_push_accepted = oacc_r;
  assign out_status        = ostat_r;

`ifndef ASSERT_OFF
  a_fetch_after_chain: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FETCH |-> $past(state_r == S_CHAIN))
    else $error("dictionary fetch without chain step");

  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DICT_SIZE))
    else $error("stack count overflow");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r != S_IDLE)
    else $error("beat accepted without work");
`endif

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - TIFF LZW decoder unit testbench
// Builds LZW strips in the bench (encoder plus MSB-first packer that tracks
// the decoder's early width change), feeds them as push/pull beats mixed with
// random noise beats, and checks every result beat against a cycle-free
// model of the decoder held in a small scoreboard class.
// ----------------------------------------------------------------------------
module tb_top
  import tld_pkg::*;
();

  localparam logic REG_OUT_LEN = 1'b0;
  localparam logic REG_IN_LEN  = 1'b1;
  localparam int   LEN_MAX     = 24'hFF_FFFF;
  localparam int   IDLE_LIMIT  = 20000;
  localparam int   DRAIN_WAIT  = 40;

  typedef struct {
    logic       got_byte;
    logic [7:0] data;
    logic       taken;
    logic [2:0] status;
  } beat_t;

  typedef int int_q_t[$];

  // --------------------------------------------------------------------------
  // Decoder model plus store of expected result beats
  // --------------------------------------------------------------------------
  class lzw_scoreboard;
    int          pfx [DICT_SIZE_DEF];
    bit [7:0]    sfx [DICT_SIZE_DEF];
    bit [7:0]    fch [DICT_SIZE_DEF];
    bit [7:0]    stk [DICT_SIZE_DEF];
    int          stk_n, bbuf, nbits, cw, nxt, prv, bout, bin;
    bit          pv;
    run_status_t st;
    int          out_len, in_len;
    beat_t       expected_q[$];
    int          mismatches, n_items, n_checked, n_bytes_out, n_pushed;
    int          stops [5];

    function void restart_state();
      stk_n = 0; bbuf = 0; nbits = 0; cw = MIN_CODE_BITS; nxt = CODE_FIRST;
      prv = 0; pv = 0; bout = 0; bin = 0; st = ST_RUN;
    endfunction

    function void set_reg(logic idx, int val);
      if (idx == REG_OUT_LEN) out_len = val & LEN_MAX;
      else in_len = val & LEN_MAX;
    endfunction

    function int first_of(int c);
      return (c < ROOT_COUNT) ? c : fch[c];
    endfunction

    // Pull one code off the bit buffer and stack its string
    function void decode_code();
      int shift, code, cur;
      shift = nbits - cw;
      code  = (bbuf >> shift) & ((1 << cw) - 1);
      nbits = shift;
      bbuf &= (1 << nbits) - 1;
      if (code == CODE_CLEAR) begin
        cw = MIN_CODE_BITS; nxt = CODE_FIRST; pv = 0;
        return;
      end
      if (code == CODE_END) begin
        st = ST_END;
        return;
      end
      if (code > nxt || (code == nxt && !pv)) begin
        st = ST_ERR; stk_n = 0;
        return;
      end
      stk_n = 0;
      cur = code;
      if (code == nxt) begin
        stk[stk_n] = first_of(prv); stk_n++;
        cur = prv;
      end
      while (cur >= ROOT_COUNT && stk_n < DICT_SIZE_DEF - 1) begin
        stk[stk_n] = sfx[cur]; stk_n++;
        cur = pfx[cur];
      end
      stk[stk_n] = cur[7:0]; stk_n++;
      if (pv && nxt < DICT_SIZE_DEF) begin
        pfx[nxt] = prv;
        sfx[nxt] = stk[stk_n - 1];
        fch[nxt] = first_of(prv);
        nxt++;
        if (nxt == (1 << cw) - 1 && cw < MAX_CODE_BITS_DEF) cw++;
      end
      prv = code; pv = 1;
    endfunction

    function void settle();
      while (st == ST_RUN) begin
        if (bout >= out_len) begin
          st = ST_LEN; stk_n = 0;
          break;
        end
        if (stk_n > 0) break;
        if (nbits < cw) begin
          if (bin >= in_len) st = ST_INEX;
          break;
        end
        decode_code();
      end
    endfunction

    // Note an accepted input beat; returns whether a push was taken
    function bit note_input(op_t op, logic [7:0] b);
      beat_t e;
      e = '{got_byte: 1'b0, data: 8'd0, taken: 1'b0, status: 3'd0};
      case (op)
        OP_PUSH: begin
          if (st == ST_RUN && bin < in_len && nbits <= MAX_CODE_BITS_DEF) begin
            bbuf = (bbuf << 8) | b; nbits += 8; bin++;
            e.taken = 1'b1; n_pushed++;
          end
        end
        OP_PULL: begin
          if (st == ST_RUN && bout < out_len && stk_n > 0) begin
            stk_n--;
            e.data = stk[stk_n]; e.got_byte = 1'b1;
            bout++; n_bytes_out++;
          end
        end
        OP_RESTART: restart_state();
        default: ;
      endcase
      settle();
      e.status = st;
      expected_q.push_back(e);
      n_items++;
      return e.taken;
    endfunction

    function void check_result(beat_t a);
      beat_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: result beat with nothing expected");
        return;
      end
      e = expected_q.pop_front();
      n_checked++;
      if (a.got_byte !== e.got_byte || a.data !== e.data || a.taken !== e.taken ||
          a.status !== e.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: beat %0d exp %0b/%02h/%0b/%0d got %0b/%02h/%0b/%0d",
                   n_checked, e.got_byte, e.data, e.taken, e.status,
                   a.got_byte, a.data, a.taken, a.status);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, block
  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_opcode = OP_NOP;
  logic [7:0]  in_data_byte = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_out_valid;
  logic [7:0]  out_out_byte;
  logic        out_push_accepted;
  logic [2:0]  out_status;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [23:0] cfg_wdata = 24'd0;

  lzw_scoreboard sb = new();
  bit            steady = 1'b0;
  int            idle_cycles = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  tiff_lzw_decoder_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_data_byte      (in_data_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_out_valid     (out_out_valid),
    .out_out_byte      (out_out_byte),
    .out_push_accepted (out_push_accepted),
    .out_status        (out_status),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Result side: random back-pressure, checking, watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 31);
    if (rst_n && out_valid && out_ready)
      sb.check_result('{got_byte: out_out_valid, data: out_out_byte,
                        taken: out_push_accepted, status: out_status});
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("tiff_lzw_decoder_unit verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stream building
  // --------------------------------------------------------------------------
  // Pack codes MSB first, widening as the decoder will
  function automatic void pack_codes(input int_q_t codes, output int_q_t bytes);
    int acc, nb, w, nx;
    bit pvalid;
    bytes = {};
    acc = 0; nb = 0; w = MIN_CODE_BITS; nx = CODE_FIRST; pvalid = 0;
    foreach (codes[i]) begin
      acc = (acc << w) | codes[i];
      nb += w;
      while (nb >= 8) begin
        bytes.push_back((acc >> (nb - 8)) & 8'hFF);
        nb -= 8;
        acc &= (1 << nb) - 1;
      end
      if (codes[i] == CODE_CLEAR) begin
        w = MIN_CODE_BITS; nx = CODE_FIRST; pvalid = 0;
      end else if (codes[i] != CODE_END) begin
        if (pvalid && nx < DICT_SIZE_DEF) begin
          nx++;
          if (nx == (1 << w) - 1 && w < MAX_CODE_BITS_DEF) w++;
        end
        pvalid = 1;
      end
    end
    // pad the last byte with random bits
    if (nb > 0)
      bytes.push_back(((acc << (8 - nb)) | $urandom_range((1 << (8 - nb)) - 1)) & 8'hFF);
  endfunction

  // Random data over an alphabet of alpha symbols, LZW-encoded, with optional mid clears
  function automatic void lzw_encode(input int dlen, input int alpha, input int clr_pct,
                                     output int_q_t codes);
    int dict [int];
    int cur, nx, b, key;
    codes = {};
    cur = -1; nx = CODE_FIRST;
    for (int i = 0; i < dlen; i++) begin
      b = $urandom_range(alpha - 1);
      key = cur * 256 + b;
      if (cur < 0) cur = b;
      else if (dict.exists(key)) cur = dict[key];
      else begin
        codes.push_back(cur);
        if (nx < DICT_SIZE_DEF) begin
          dict[key] = nx; nx++;
        end
        cur = b;
        if ($urandom_range(99) < clr_pct) begin
          codes.push_back(CODE_CLEAR);
          dict.delete(); nx = CODE_FIRST;
        end
      end
    end
    if (cur >= 0) codes.push_back(cur);
    codes.push_back(CODE_END);
  endfunction

  // --------------------------------------------------------------------------
  // Driving
  // --------------------------------------------------------------------------
  task automatic send(input op_t op, input logic [7:0] b, output bit taken);
    if (!steady && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_opcode    <= op;
    in_data_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    taken = sb.note_input(op, b);
  endtask

  // Drop valid, let every result arrive and the block settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_lengths(input int olen, input int ilen);
    cfg_we    <= 1'b1;
    cfg_index <= REG_OUT_LEN;
    cfg_wdata <= olen[23:0];
    sb.set_reg(REG_OUT_LEN, olen);
    @(posedge clk);
    cfg_index <= REG_IN_LEN;
    cfg_wdata <= ilen[23:0];
    sb.set_reg(REG_IN_LEN, ilen);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // One strip: program lengths, restart, then mix pushes, pulls and noise
  task automatic run_strip(input int_q_t bytes, input int olen, input int ilen,
                           input int dlen);
    int  ptr, guard, r;
    bit  taken;
    op_t op;
    wait_idle();
    write_lengths(olen, ilen);
    send(OP_RESTART, 8'($urandom), taken);
    ptr = 0;
    guard = 6 * bytes.size() + 6 * dlen + 60;
    while (sb.st == ST_RUN && guard > 0) begin
      guard--;
      r = $urandom_range(99);
      if (r < 6) begin
        op = op_t'($urandom_range(3));
        if (op == OP_RESTART && $urandom_range(3) != 0) op = OP_NOP;
        send(op, 8'($urandom), taken);
      end else if (sb.stk_n > 0 &&
                   (sb.nbits > MAX_CODE_BITS_DEF || ptr >= bytes.size() || r < 60)) begin
        send(OP_PULL, 8'($urandom), taken);
      end else if (ptr < bytes.size()) begin
        send(OP_PUSH, bytes[ptr][7:0], taken);
        if (taken) ptr++;
      end else begin
        send(OP_PUSH, 8'($urandom), taken);
      end
    end
    // beats after the stop are refused or empty
    repeat (2) send(op_t'($urandom_range(1, 0)), 8'($urandom), taken);
    sb.stops[sb.st]++;
  endtask

  task automatic run_codes(input int_q_t codes, input int olen, input int ilen);
    int_q_t bytes;
    pack_codes(codes, bytes);
    run_strip(bytes, olen, ilen < 0 ? bytes.size() : ilen, 3 * codes.size());
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int_q_t codes, bytes;
    int     dlen, olen, ilen, r, wait_cnt, n_strips;
    sb.out_len = 0; sb.in_len = 0;
    sb.restart_state();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: repeated-string code, clears, bad codes, stops of each kind
    run_codes('{CODE_CLEAR, 65, 66, 258, 260, CODE_END}, LEN_MAX, LEN_MAX);
    run_codes('{CODE_FIRST}, LEN_MAX, -1);
    run_codes('{CODE_CLEAR, 65, 300}, LEN_MAX, -1);
    run_codes('{0, 255, CODE_END}, 0, -1);
    run_codes('{0, 255, 258, CODE_END}, 5, -1);
    run_codes('{65, 66, 67, CODE_END}, 2, -1);
    run_codes('{65, 66, 67, 68}, LEN_MAX, -1);
    run_codes('{65, 66, CODE_CLEAR, 67, 258, CODE_END}, LEN_MAX, -1);
    run_codes('{65, 66, CODE_END}, LEN_MAX, 0);
    run_codes('{CODE_END}, LEN_MAX, 1);

    // One longer strip: enough new entries to widen codes to ten bits
    lzw_encode(270, 256, 0, codes);
    run_codes(codes, LEN_MAX, -1);

    // Random strips
    n_strips = 0;
    while (sb.n_items < 900 || n_strips < 8) begin
      steady = (n_strips >= 4 && n_strips < 7);
      dlen = $urandom_range(1, 16);
      lzw_encode(dlen, $urandom_range(1, 256), 3, codes);
      pack_codes(codes, bytes);
      if ($urandom_range(9) < 3) bytes.push_back($urandom_range(255));
      r = $urandom_range(99);
      olen = (r < 60) ? dlen : (r < 75) ? $urandom_range(dlen) :
             (r < 90) ? LEN_MAX : dlen + $urandom_range(1, 20);
      r = $urandom_range(99);
      ilen = (r < 70) ? bytes.size() : (r < 85) ? LEN_MAX : $urandom_range(bytes.size());
      run_strip(bytes, olen, ilen, dlen);
      n_strips++;
    end
    steady = 1'b0;

    in_valid <= 1'b0;
    wait_cnt = 0;
    while (sb.expected_q.size() != 0 && wait_cnt < IDLE_LIMIT) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Covered %0d beats over %0d random strips plus directed ones:",
             sb.n_items, n_strips);
    $display("  %0d bytes pushed, %0d decoded bytes pulled.",
             sb.n_pushed, sb.n_bytes_out);
    $display("Strip endings: end code %0d, length %0d, input out %0d, error %0d;",
             sb.stops[ST_END], sb.stops[ST_LEN], sb.stops[ST_INEX], sb.stops[ST_ERR]);
    $display("  mismatches %0d.", sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("tiff_lzw_decoder_unit verification clean");
    end else begin
      $display("tiff_lzw_decoder_unit verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/tld_pkg.sv
sv/tld_dict.sv
sv/tld_stack.sv
sv/tiff_lzw_decoder_unit.sv
tb/tb_top.sv
